// ----- hdl/ecs_pkg.sv -----
// Package for the ellipse cell scan unit: default sizes, register map,
// state types and the request/response structs of the paint evaluator.
// No dependencies; ecs_paint_eval and ellipse_cell_scan_unit import this package.
package ecs_pkg;

    // Default sizes of coordinates and radii.
    localparam int COORD_BITS_DEF  = 10;
    localparam int RADIUS_BITS_DEF = 9;

    // Configuration port geometry.
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Register indexes (byte address divided by four).
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_RADIUS_V  = 3'd0;
    localparam reg_idx_t REG_RADIUS_H  = 3'd1;
    localparam reg_idx_t REG_CENTER_R  = 3'd2;
    localparam reg_idx_t REG_CENTER_C  = 3'd3;
    localparam reg_idx_t REG_COLOUR    = 3'd4;
    localparam reg_idx_t REG_DRAW_MODE = 3'd5;

    // Top-level item sequencer.
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_EVAL,
        TS_OUT
    } scan_state_t;

    // Paint evaluator sequencer: one step of the shared multiplier or
    // of the scaling adders per state.
    typedef enum logic [3:0] {
        EV_IDLE,
        EV_SQ_I,
        EV_SQ_J,
        EV_SQ_RV,
        EV_SQ_RH,
        EV_MUL_A,
        EV_MUL_B,
        EV_MUL_D,
        EV_SCALE,
        EV_BAND_LO,
        EV_BAND_HI
    } eval_state_t;

    // Request from the scan sequencer to the evaluator.
    typedef struct packed {
        logic start;
        logic fill;
    } eval_req_t;

    // Response from the evaluator.
    typedef struct packed {
        logic done;
        logic paint;
    } eval_rsp_t;

endpackage

// ----- hdl/ecs_in_if.sv -----
// Input channel of the ellipse cell scan unit: valid/ready and the restart flag.
// No dependencies.
interface ecs_in_if;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);

endinterface

// ----- hdl/ecs_out_if.sv -----
// Output channel of the ellipse cell scan unit: valid/ready and one cell item.
// No dependencies; the position width follows COORD_BITS.
interface ecs_out_if #(
    parameter int COORD_BITS = 10
);

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS:0]   cell_row;
    logic [COORD_BITS:0]   cell_col;
    logic                  paint;
    logic [7:0]            cell_colour;
    logic                  last;
    logic                  status;

    modport source (
        output valid, output cell_row, output cell_col, output paint,
        output cell_colour, output last, output status, input ready
    );
    modport sink (
        input valid, input cell_row, input cell_col, input paint,
        input cell_colour, input last, input status, output ready
    );

endinterface

// ----- hdl/ecs_paint_eval.sv -----
// Paint evaluator: decides whether one cell lies inside the ellipse or its
// outline band, using one shared multiplier under a small sequencer. Uses ecs_pkg.
module ecs_paint_eval import ecs_pkg::*; #(
    parameter int  COORD_BITS  = COORD_BITS_DEF,
    parameter int  RADIUS_BITS = RADIUS_BITS_DEF,
    localparam int DW = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  eval_req_t              req,
    input  logic [DW-1:0]          di,
    input  logic [DW-1:0]          dj,
    input  logic [RADIUS_BITS-1:0] rv,
    input  logic [RADIUS_BITS-1:0] rh,
    output eval_rsp_t              rsp
);

    localparam int MW  = 2 * DW;           // multiplier operand width
    localparam int PRW = 2 * MW;           // multiplier product width
    localparam int R2W = 2 * RADIUS_BITS;  // squared radius
    localparam int NPW = MW + R2W;         // one term of the numerator
    localparam int NW  = NPW + 1;          // numerator
    localparam int DDW = 2 * R2W;          // denominator
    localparam int SW  = NW + 5;           // scaled values for the band test

    eval_state_t      state_reg;
    eval_state_t      state_next;

    logic [DW-1:0]    di_reg;
    logic [DW-1:0]    dj_reg;
    logic             fill_reg;
    logic [MW-1:0]    sqi_reg;
    logic [MW-1:0]    sqj_reg;
    logic [R2W-1:0]   rv2_reg;
    logic [R2W-1:0]   rh2_reg;
    logic [NPW-1:0]   na_reg;
    logic [NPW-1:0]   nb_reg;
    logic [NW-1:0]    n_reg;
    logic [DDW-1:0]   d_reg;
    logic [SW-1:0]    n20_reg;
    logic [SW-1:0]    d17_reg;
    logic [SW-1:0]    d23_reg;
    logic             fill_ok_reg;
    logic             lo_ok_reg;

    logic [MW-1:0]    mul_a;
    logic [MW-1:0]    mul_b;
    logic [PRW-1:0]   prod;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a fixed chain of steps once started.
    always_comb
    begin
        unique case (state_reg)
            EV_IDLE:    state_next = req.start ? EV_SQ_I : EV_IDLE;
            EV_SQ_I:    state_next = EV_SQ_J;
            EV_SQ_J:    state_next = EV_SQ_RV;
            EV_SQ_RV:   state_next = EV_SQ_RH;
            EV_SQ_RH:   state_next = EV_MUL_A;
            EV_MUL_A:   state_next = EV_MUL_B;
            EV_MUL_B:   state_next = EV_MUL_D;
            EV_MUL_D:   state_next = EV_SCALE;
            EV_SCALE:   state_next = EV_BAND_LO;
            EV_BAND_LO: state_next = EV_BAND_HI;
            EV_BAND_HI: state_next = EV_IDLE;
            default:    state_next = EV_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            EV_SQ_I:
            begin
                mul_a = MW'(di_reg);
                mul_b = MW'(di_reg);
            end
            EV_SQ_J:
            begin
                mul_a = MW'(dj_reg);
                mul_b = MW'(dj_reg);
            end
            EV_SQ_RV:
            begin
                mul_a = MW'(rv);
                mul_b = MW'(rv);
            end
            EV_SQ_RH:
            begin
                mul_a = MW'(rh);
                mul_b = MW'(rh);
            end
            EV_MUL_A:
            begin
                mul_a = sqi_reg;
                mul_b = MW'(rh2_reg);
            end
            EV_MUL_B:
            begin
                mul_a = sqj_reg;
                mul_b = MW'(rv2_reg);
            end
            EV_MUL_D:
            begin
                mul_a = MW'(rv2_reg);
                mul_b = MW'(rh2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PRW'(mul_a) * PRW'(mul_b);

    // Datapath registers, each loaded in a set step of the sequencer.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            EV_IDLE:
            begin
                if (req.start)
                begin
                    di_reg   <= di;
                    dj_reg   <= dj;
                    fill_reg <= req.fill;
                end
            end
            EV_SQ_I:  sqi_reg <= prod[MW-1:0];
            EV_SQ_J:  sqj_reg <= prod[MW-1:0];
            EV_SQ_RV: rv2_reg <= prod[R2W-1:0];
            EV_SQ_RH: rh2_reg <= prod[R2W-1:0];
            EV_MUL_A: na_reg  <= prod[NPW-1:0];
            EV_MUL_B: nb_reg  <= prod[NPW-1:0];
            EV_MUL_D:
            begin
                d_reg <= prod[DDW-1:0];
                n_reg <= NW'(na_reg) + NW'(nb_reg);
            end
            EV_SCALE:
            begin
                // Twenty times the numerator, seventeen times the denominator.
                n20_reg     <= (SW'(n_reg) << 4) + (SW'(n_reg) << 2);
                d17_reg     <= (SW'(d_reg) << 4) + SW'(d_reg);
                fill_ok_reg <= SW'(n_reg) <= SW'(d_reg);
            end
            EV_BAND_LO:
            begin
                lo_ok_reg <= d17_reg <= n20_reg;
                d23_reg   <= d17_reg + (SW'(d_reg) << 2) + (SW'(d_reg) << 1);
            end
            default:
            begin
            end
        endcase
    end

    // The verdict is ready in the final step.
    always_comb
    begin
        rsp.done  = (state_reg == EV_BAND_HI);
        rsp.paint = fill_reg ? fill_ok_reg : (lo_ok_reg && (n20_reg <= d23_reg));
    end

endmodule

// ----- hdl/ellipse_cell_scan_unit.sv -----
// Ellipse cell scan unit: each input item yields one cell of the bounding box
// of the configured ellipse, scanned row by row, left to right, with its
// screen position, colour and a paint flag (fill mode: inside the ellipse;
// outline mode: squared normalized distance from 0.85 to 1.15, tested exactly
// by integer cross-multiplication). A restart item, or any item after the
// last cell, begins a new scan; a centre too close to the top or left edge
// gives a single item with status set and skips the paint test. For an
// ordinary cell the paint test runs ten steps through one shared multiplier
// and its scaling adders; a new item is accepted only once the previous one
// has left the output. Registers must be written only while idle.
// Depends on ecs_pkg, ecs_in_if, ecs_out_if and ecs_paint_eval.
module ellipse_cell_scan_unit import ecs_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ecs_in_if.sink               in_ch,
    ecs_out_if.source            out_ch,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam int DW  = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
    localparam int PSW = DW + 1;

    // Configuration registers.
    logic [RADIUS_BITS-1:0] radius_v_reg;
    logic [RADIUS_BITS-1:0] radius_h_reg;
    logic [COORD_BITS-1:0]  center_r_reg;
    logic [COORD_BITS-1:0]  center_c_reg;
    logic [7:0]             colour_reg;
    logic                   draw_mode_reg;

    // Scan state.
    logic [COORD_BITS-1:0]  row_offset_reg;
    logic [COORD_BITS-1:0]  col_offset_reg;
    logic                   armed_reg;
    scan_state_t            state_reg;
    scan_state_t            state_next;

    // Result item registers.
    logic [COORD_BITS:0]    cell_row_reg;
    logic [COORD_BITS:0]    cell_col_reg;
    logic                   paint_reg;
    logic [7:0]             cell_colour_reg;
    logic                   last_reg;
    logic                   status_reg;
    logic                   zero_reg;

    logic                   accept;
    logic                   cfg_write;
    reg_idx_t               cfg_idx;
    logic                   scan_start;
    logic                   edge_err;
    logic [COORD_BITS-1:0]  eff_row;
    logic [COORD_BITS-1:0]  eff_col;
    logic                   row_end;
    logic                   col_end;
    logic [PSW-1:0]         row_pos;
    logic [PSW-1:0]         col_pos;
    logic [DW-1:0]          di;
    logic [DW-1:0]          dj;
    eval_req_t              req;
    eval_rsp_t              rsp;

    // Configuration port: writes in the access phase, reads always.
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_v_reg  <= '0;
            radius_h_reg  <= '0;
            center_r_reg  <= '0;
            center_c_reg  <= '0;
            colour_reg    <= '0;
            draw_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_RADIUS_V:  radius_v_reg  <= pwdata[RADIUS_BITS-1:0];
                REG_RADIUS_H:  radius_h_reg  <= pwdata[RADIUS_BITS-1:0];
                REG_CENTER_R:  center_r_reg  <= pwdata[COORD_BITS-1:0];
                REG_CENTER_C:  center_c_reg  <= pwdata[COORD_BITS-1:0];
                REG_COLOUR:    colour_reg    <= pwdata[7:0];
                REG_DRAW_MODE: draw_mode_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RADIUS_V:  prdata = DATA_BITS'(radius_v_reg);
            REG_RADIUS_H:  prdata = DATA_BITS'(radius_h_reg);
            REG_CENTER_R:  prdata = DATA_BITS'(center_r_reg);
            REG_CENTER_C:  prdata = DATA_BITS'(center_c_reg);
            REG_COLOUR:    prdata = DATA_BITS'(colour_reg);
            REG_DRAW_MODE: prdata = DATA_BITS'(draw_mode_reg);
            default:       prdata = '0;
        endcase
    end

    // Cell selection and geometry for the item being accepted.
    assign accept     = in_ch.valid && in_ch.ready;
    assign scan_start = in_ch.restart || !armed_reg;
    assign edge_err   = scan_start &&
                        ((DW'(center_r_reg) <= DW'(radius_v_reg)) ||
                         (DW'(center_c_reg) <= DW'(radius_h_reg)));
    assign eff_row    = scan_start ? '0 : row_offset_reg;
    assign eff_col    = scan_start ? '0 : col_offset_reg;
    assign row_end    = PSW'(eff_row) >= (PSW'(radius_v_reg) << 1);
    assign col_end    = PSW'(eff_col) >= (PSW'(radius_h_reg) << 1);
    assign row_pos    = PSW'(center_r_reg) + PSW'(eff_row) - PSW'(radius_v_reg);
    assign col_pos    = PSW'(center_c_reg) + PSW'(eff_col) - PSW'(radius_h_reg);

    // Distances of the cell from the centre, as magnitudes.
    always_comb
    begin
        if (DW'(eff_row) >= DW'(radius_v_reg))
        begin
            di = DW'(eff_row) - DW'(radius_v_reg);
        end
        else
        begin
            di = DW'(radius_v_reg) - DW'(eff_row);
        end
        if (DW'(eff_col) >= DW'(radius_h_reg))
        begin
            dj = DW'(eff_col) - DW'(radius_h_reg);
        end
        else
        begin
            dj = DW'(radius_h_reg) - DW'(eff_col);
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        unique case (state_reg)
            TS_IDLE:
            begin
                if (accept)
                begin
                    state_next = edge_err ? TS_OUT : TS_EVAL;
                end
                else
                begin
                    state_next = TS_IDLE;
                end
            end
            TS_EVAL: state_next = rsp.done ? TS_OUT : TS_EVAL;
            TS_OUT:  state_next = out_ch.ready ? TS_IDLE : TS_OUT;
            default: state_next = TS_IDLE;
        endcase
    end

    // Handshake and evaluator control.
    always_comb
    begin
        in_ch.ready  = (state_reg == TS_IDLE);
        out_ch.valid = (state_reg == TS_OUT);
        req.start    = accept && !edge_err;
        req.fill     = draw_mode_reg;
    end

    // Scan position advances when an item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_offset_reg <= '0;
            col_offset_reg <= '0;
            armed_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (edge_err || (row_end && col_end))
            begin
                row_offset_reg <= '0;
                col_offset_reg <= '0;
                armed_reg      <= 1'b0;
            end
            else if (col_end)
            begin
                row_offset_reg <= eff_row + COORD_BITS'(1);
                col_offset_reg <= '0;
                armed_reg      <= 1'b1;
            end
            else
            begin
                row_offset_reg <= eff_row;
                col_offset_reg <= eff_col + COORD_BITS'(1);
                armed_reg      <= 1'b1;
            end
        end
    end

    // Result item: geometry on acceptance, paint flag from the evaluator.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (edge_err)
            begin
                cell_row_reg    <= '0;
                cell_col_reg    <= '0;
                cell_colour_reg <= '0;
                last_reg        <= 1'b1;
                status_reg      <= 1'b1;
            end
            else
            begin
                cell_row_reg    <= row_pos[COORD_BITS:0];
                cell_col_reg    <= col_pos[COORD_BITS:0];
                cell_colour_reg <= colour_reg;
                last_reg        <= row_end && col_end;
                status_reg      <= 1'b0;
            end
            paint_reg <= 1'b0;
            zero_reg  <= (radius_v_reg == '0) || (radius_h_reg == '0);
        end
        else if ((state_reg == TS_EVAL) && rsp.done)
        begin
            // A zero radius paints nothing.
            paint_reg <= rsp.paint && !zero_reg;
        end
    end

    assign out_ch.cell_row    = cell_row_reg;
    assign out_ch.cell_col    = cell_col_reg;
    assign out_ch.paint       = paint_reg;
    assign out_ch.cell_colour = cell_colour_reg;
    assign out_ch.last        = last_reg;
    assign out_ch.status      = status_reg;

    ecs_paint_eval #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .di    (di),
        .dj    (dj),
        .rv    (radius_v_reg),
        .rh    (radius_h_reg),
        .rsp   (rsp)
    );

endmodule
